// ===== hw/rtl/seeded_prng_zero_streak_search_macros.svh =====
// Assertion macros shared by the zero-streak search modules.
`ifndef SEEDED_PRNG_ZERO_STREAK_SEARCH_MACROS_SVH
`define SEEDED_PRNG_ZERO_STREAK_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SZS_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define SZS_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/szs_pkg.sv =====
// Package with constants, command codes and interface structs of the zero-streak search.
package szs_pkg;

  localparam int SEED_W     = 64;
  localparam int BOUND_W    = 31;
  localparam int THRESH_W   = 11;
  localparam int STREAK_W   = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int STEP_W     = 5;
  localparam int DIV_CNT_W  = 6;
  localparam int MAX_DRAWS_DEF = 1024;

  localparam logic [DIV_CNT_W-1:0] DIV_TOP   = DIV_CNT_W'(BOUND_W + 1);
  localparam logic [STEP_W-1:0]    SEED_LAST = 5'd16;

  localparam logic [BOUND_W-1:0]  BOUND_RST  = 31'd3;
  localparam logic [THRESH_W-1:0] THRESH_RST = 11'd19;

  localparam logic [63:0] K_GOLDEN  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] K_SILVER  = 64'h6a09e667f3bcc909;
  localparam logic [63:0] K_SALT_LO = 64'ha00e2b904f10208b;
  localparam logic [63:0] K_SALT_HI = 64'h61ced0c97606ee23;
  localparam logic [63:0] K_MIX_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] K_MIX_B   = 64'h94d049bb133111eb;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAW_BOUND       = 1'b0,
    REG_STREAK_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_XS30,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_XS27,
    OP_FIN_LO,
    OP_FIN_HI,
    OP_DRAW,
    OP_CAPTURE,
    OP_DIV_START,
    OP_DIV_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mix_b;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic done;
    logic out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/szs_datapath.sv =====
// Datapath: config registers, limit divider, seeding mixer, generator, draw judge and output word.
`include "seeded_prng_zero_streak_search_macros.svh"

module szs_datapath #(
  parameter int MAX_DRAWS = szs_pkg::MAX_DRAWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  szs_pkg::cmd_t                 cmd,
  output szs_pkg::stat_t                stat,
  input  logic                          wr_en,
  input  logic [szs_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [szs_pkg::BOUND_W-1:0]   wr_data,
  input  logic [szs_pkg::SEED_W-1:0]    seed_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [szs_pkg::SEED_W-1:0]    seed_echo,
  output logic [szs_pkg::STREAK_W-1:0]  zero_streak,
  output logic                          hit,
  output logic                          saturated
);
  import szs_pkg::*;

  localparam int CNT_W = $clog2(MAX_DRAWS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DRAWS);

  logic [BOUND_W-1:0]   bound;
  logic [THRESH_W-1:0]  thresh;
  logic [BOUND_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [63:0]          x;
  logic [63:0]          acc;
  logic [63:0]          lo;
  logic [63:0]          hi;
  logic [SEED_W-1:0]    seed_r;
  logic [31:0]          out32;
  logic                 s1_v;
  logic                 s2_v;
  logic [CNT_W-1:0]     streak;

  logic [63:0]      kconst;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic [63:0]      mixed;
  logic [63:0]      gen_sum;
  logic [63:0]      gen_out;
  logic [63:0]      gen_t;
  logic [31:0]      div_r;
  logic [31:0]      div_r_next;
  logic             rejected;
  logic             nonzero;
  logic             judged_done;
  logic [CNT_W-1:0] streak_plus;
  logic [31:0]      streak_wide;

  assign kconst = cmd.mix_b ? K_MIX_B : K_MIX_A;

  always_comb begin
    case (cmd.op)
      OP_MUL1: begin
        mul_a = x[31:0];
        mul_b = kconst[63:32];
      end
      OP_MUL2: begin
        mul_a = x[63:32];
        mul_b = kconst[31:0];
      end
      OP_DRAW: begin
        mul_a = out32;
        mul_b = {1'b0, bound};
      end
      default: begin
        mul_a = x[31:0];
        mul_b = kconst[31:0];
      end
    endcase
  end

  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign mixed   = acc ^ (acc >> 31);
  assign gen_sum = lo + hi;
  assign gen_out = {gen_sum[46:0], gen_sum[63:47]} + lo;
  assign gen_t   = hi ^ lo;

  assign div_r      = {rem, (dcnt == DIV_TOP)};
  assign div_r_next = (div_r >= {1'b0, bound}) ? (div_r - {1'b0, bound}) : div_r;

  assign rejected    = (bound != '0) && (acc[31:0] < {1'b0, rem});
  assign nonzero     = (acc[63:32] != 32'd0);
  assign streak_plus = streak + CNT_W'(1);
  assign judged_done = (cmd.op == OP_DRAW) && s2_v && !rejected &&
                       (nonzero || (streak_plus == CNT_MAX));
  assign streak_wide = 32'(streak);

  assign stat.div_last = (dcnt == '0);
  assign stat.done     = judged_done;
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound     <= BOUND_RST;
      thresh    <= THRESH_RST;
      out_valid <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      streak    <= '0;
      dcnt      <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_DRAW_BOUND:       bound  <= wr_data;
          REG_STREAK_THRESHOLD: thresh <= wr_data[THRESH_W-1:0];
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_NOP: begin
        end
        OP_LOAD: begin
          seed_r <= seed_value;
          x      <= seed_value ^ K_SILVER ^ K_SALT_LO;
          hi     <= ((seed_value ^ K_SILVER) + K_GOLDEN) ^ K_SALT_HI;
          streak <= '0;
          s1_v   <= 1'b0;
          s2_v   <= 1'b0;
        end
        OP_XS30: x <= x ^ (x >> 30);
        OP_MUL0: acc <= mul_p;
        OP_MUL1, OP_MUL2: acc <= acc + {mul_p[31:0], 32'd0};
        OP_XS27: x <= acc ^ (acc >> 27);
        OP_FIN_LO: begin
          lo <= mixed;
          x  <= hi ^ (hi >> 30);
        end
        OP_FIN_HI: hi <= mixed;
        OP_DRAW: begin
          out32 <= gen_out[31:0];
          lo    <= {lo[14:0], lo[63:15]} ^ gen_t ^ (gen_t << 21);
          hi    <= {gen_t[35:0], gen_t[63:36]};
          s1_v  <= 1'b1;
          acc   <= mul_p;
          s2_v  <= s1_v;
          if (s2_v && !rejected && !nonzero) begin
            streak <= streak_plus;
          end
        end
        OP_CAPTURE: begin
          seed_echo   <= seed_r;
          zero_streak <= streak_wide[STREAK_W-1:0];
          hit         <= (streak != '0) && (streak_wide >= 32'(thresh));
          saturated   <= (streak == CNT_MAX);
          out_valid   <= 1'b1;
        end
        OP_DIV_START: begin
          rem  <= '0;
          dcnt <= DIV_TOP;
        end
        OP_DIV_STEP: begin
          rem <= div_r_next[BOUND_W-1:0];
          if (dcnt != '0) begin
            dcnt <= dcnt - DIV_CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  `SZS_ASSERT_IMP(a_streak_in_range, 1'b1, streak <= CNT_MAX)
  `SZS_ASSERT_NXT(a_capture_fills_output, cmd.op == OP_CAPTURE, out_valid)
  `SZS_ASSERT_IMP(a_draw_pipe_order, s2_v, s1_v)

endmodule

// ===== hw/rtl/szs_ctrl.sv =====
// Controller state machine that sequences limit setup, seeding, drawing and output capture.
`include "seeded_prng_zero_streak_search_macros.svh"

module szs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          wr_en,
  input  logic [szs_pkg::CFG_IDX_W-1:0] wr_index,
  input  szs_pkg::stat_t                stat,
  output szs_pkg::cmd_t                 cmd
);
  import szs_pkg::*;

  typedef enum logic [2:0] {
    ST_DIV_INIT,
    ST_DIV,
    ST_IDLE,
    ST_SEED,
    ST_DRAW,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              bound_wr;

  function automatic cmd_t seed_cmd(input logic [STEP_W-1:0] s);
    cmd_t c;
    c.mix_b = 1'b0;
    unique case (s)
      5'd0:  c.op = OP_XS30;
      5'd1:  c.op = OP_MUL0;
      5'd2:  c.op = OP_MUL1;
      5'd3:  c.op = OP_MUL2;
      5'd4:  c.op = OP_XS27;
      5'd5:  begin c.op = OP_MUL0; c.mix_b = 1'b1; end
      5'd6:  begin c.op = OP_MUL1; c.mix_b = 1'b1; end
      5'd7:  begin c.op = OP_MUL2; c.mix_b = 1'b1; end
      5'd8:  c.op = OP_FIN_LO;
      5'd9:  c.op = OP_MUL0;
      5'd10: c.op = OP_MUL1;
      5'd11: c.op = OP_MUL2;
      5'd12: c.op = OP_XS27;
      5'd13: begin c.op = OP_MUL0; c.mix_b = 1'b1; end
      5'd14: begin c.op = OP_MUL1; c.mix_b = 1'b1; end
      5'd15: begin c.op = OP_MUL2; c.mix_b = 1'b1; end
      5'd16: c.op = OP_FIN_HI;
      default: c.op = OP_NOP;
    endcase
    return c;
  endfunction

  assign bound_wr = wr_en && (wr_index == REG_DRAW_BOUND);
  assign in_ready = (state == ST_IDLE) && !bound_wr;

  always_comb begin
    cmd.op    = OP_NOP;
    cmd.mix_b = 1'b0;
    unique case (state)
      ST_DIV_INIT: cmd.op = OP_DIV_START;
      ST_DIV:      cmd.op = OP_DIV_STEP;
      ST_IDLE:     cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_NOP;
      ST_SEED:     cmd = seed_cmd(step);
      ST_DRAW:     cmd.op = OP_DRAW;
      ST_FINISH:   cmd.op = stat.out_busy ? OP_NOP : OP_CAPTURE;
      default:     cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DIV_INIT;
      step  <= '0;
    end else if (bound_wr) begin
      state <= ST_DIV_INIT;
    end else begin
      unique case (state)
        ST_DIV_INIT: state <= ST_DIV;
        ST_DIV: begin
          if (stat.div_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SEED;
            step  <= '0;
          end
        end
        ST_SEED: begin
          if (step == SEED_LAST) begin
            state <= ST_DRAW;
          end
          step <= step + STEP_W'(1);
        end
        ST_DRAW: begin
          if (stat.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!stat.out_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_DIV_INIT;
      endcase
    end
  end

  `SZS_ASSERT_NXT(a_accept_blocks_next, in_valid && in_ready, !in_ready)
  `SZS_ASSERT_NXT(a_bound_write_blocks_input, bound_wr, !in_ready)
  `SZS_ASSERT_IMP(a_capture_only_when_free, cmd.op == OP_CAPTURE, !stat.out_busy)

endmodule

// ===== hw/rtl/seeded_prng_zero_streak_search.sv =====
// Top level of the seeded xoroshiro128++ zero-streak search block.
// For each 64-bit seed word the block seeds a xoroshiro128++ generator, draws bounded
// integers below draw_bound by multiply-high with rejection, and returns one word with
// the seed, the count of zero draws before the first nonzero draw (saturating at
// MAX_DRAWS), a hit flag and a saturated flag. From acceptance to the output register a
// seed goes through seeding of the generator state through one shared 32x32 multiplier,
// the filling of the draw pipeline, then one draw per cycle counting rejected draws,
// and a capture that waits while the previous word is still held at the output.
// One seed is in flight at a time; the next is taken while the previous word waits at
// the output. After reset and after each write of draw_bound the block computes the
// rejection limit (2^32 mod draw_bound) one bit per cycle, and accepts no seed meanwhile.
`include "seeded_prng_zero_streak_search_macros.svh"

module seeded_prng_zero_streak_search #(
  parameter int MAX_DRAWS = szs_pkg::MAX_DRAWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [szs_pkg::SEED_W-1:0]    seed_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [szs_pkg::SEED_W-1:0]    seed_echo,
  output logic [szs_pkg::STREAK_W-1:0]  zero_streak,
  output logic                          hit,
  output logic                          saturated,
  input  logic                          wr_en,
  input  logic [szs_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [szs_pkg::BOUND_W-1:0]   wr_data
);
  import szs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  szs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .stat     (stat),
    .cmd      (cmd)
  );

  szs_datapath #(
    .MAX_DRAWS (MAX_DRAWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .seed_echo   (seed_echo),
    .zero_streak (zero_streak),
    .hit         (hit),
    .saturated   (saturated)
  );

endmodule

// ===== bench/seeded_prng_zero_streak_search_tb.sv =====
// Self-checking testbench for the seeded xoroshiro128++ zero-streak search block.
module seeded_prng_zero_streak_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import szs_pkg::*;

  localparam int STREAK_CAP  = 1024;
  localparam int QUIET_LIMIT = 6000;

  localparam logic [63:0] GOLDEN  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SILVER  = 64'h6a09e667f3bcc909;
  localparam logic [63:0] SALT_LO = 64'ha00e2b904f10208b;
  localparam logic [63:0] SALT_HI = 64'h61ced0c97606ee23;
  localparam logic [63:0] MIX_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_B   = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [SEED_W-1:0]   seed;
    logic [STREAK_W-1:0] streak;
    logic                hit;
    logic                sat;
  } streak_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SEED_W-1:0]    seed_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SEED_W-1:0]    seed_echo;
  logic [STREAK_W-1:0]  zero_streak;
  logic                 hit;
  logic                 saturated;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [BOUND_W-1:0]   wr_data = '0;

  logic [BOUND_W-1:0]  model_bound = 31'd3;
  logic [THRESH_W-1:0] model_thresh = 11'd19;

  logic [SEED_W-1:0] seed_q[$];
  streak_word_t      streak_expect_q[$];

  bit          took_seed, offer, send_hold, long_hold_req, long_hold_done;
  int unsigned burst_left, gap_left, hold_left, rx_cycle, quiet_cycles;
  int unsigned mismatches, words_checked, hit_count, sat_count, rejected_draws;
  int unsigned longest_streak, settings_count;
  streak_word_t got, want;

  seeded_prng_zero_streak_search #(
    .MAX_DRAWS(STREAK_CAP)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .seed_value (seed_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .seed_echo  (seed_echo),
    .zero_streak(zero_streak),
    .hit        (hit),
    .saturated  (saturated),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic logic [63:0] stafford(logic [63:0] v);
    v = (v ^ (v >> 30)) * MIX_A;
    v = (v ^ (v >> 27)) * MIX_B;
    return v ^ (v >> 31);
  endfunction

  // Generator state is packed as {hi, lo}.
  function automatic logic [63:0] xoro_output(logic [127:0] st);
    return rotl64(st[63:0] + st[127:64], 17) + st[63:0];
  endfunction

  function automatic logic [127:0] xoro_advance(logic [127:0] st);
    logic [63:0] t;
    t = st[127:64] ^ st[63:0];
    return {rotl64(t, 28), rotl64(st[63:0], 49) ^ t ^ (t << 21)};
  endfunction

  // Runs the bounded draws for one seed and returns the word the block should produce.
  function automatic streak_word_t predict_streak(logic [63:0] seed);
    logic [63:0]  a, b, prod;
    logic [127:0] st;
    logic [31:0]  bnd, lim;
    int unsigned  streak;
    streak_word_t w;
    bnd = {1'b0, model_bound};
    a = seed ^ SILVER;
    b = a + GOLDEN;
    st = {stafford(b ^ SALT_HI), stafford(a ^ SALT_LO)};
    streak = 0;
    while (streak < STREAK_CAP) begin
      prod = (xoro_output(st) & 64'hFFFF_FFFF) * {32'h0, bnd};
      st = xoro_advance(st);
      if (bnd != 0 && prod[31:0] < bnd) begin
        lim = (32'h0 - bnd) % bnd;
        while (prod[31:0] < lim) begin
          prod = (xoro_output(st) & 64'hFFFF_FFFF) * {32'h0, bnd};
          st = xoro_advance(st);
          rejected_draws++;
        end
      end
      if (prod[63:32] != 0) break;
      streak++;
    end
    w.seed = seed;
    w.streak = STREAK_W'(streak);
    w.hit = (streak != 0) && (streak >= model_thresh);
    w.sat = (streak >= STREAK_CAP);
    return w;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      seed_value <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      took_seed = in_valid && in_ready;
      if (took_seed) streak_expect_q.push_back(predict_streak(seed_value));
      if (!in_valid || took_seed) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!send_hold && seed_q.size() > 0) begin
          offer = 1'b1;
          seed_value <= seed_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= offer;
      end
    end
  end

  // Receiver: cycles through always ready, coin flip, sparse and toggling patterns.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      rx_cycle = 0;
    end else begin
      rx_cycle++;
      if (long_hold_req && !long_hold_done) begin
        hold_left = 400;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= rx_cycle[1];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = {seed_echo, zero_streak, hit, saturated};
      words_checked++;
      if (streak_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: seed %h streak %0d hit %b sat %b",
                   got.seed, got.streak, got.hit, got.sat);
      end else begin
        want = streak_expect_q.pop_front();
        if (got.seed !== want.seed || got.streak !== want.streak ||
            got.hit !== want.hit || got.sat !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected seed %h streak %0d hit %b sat %b, got %h %0d %b %b",
                     want.seed, want.streak, want.hit, want.sat,
                     got.seed, got.streak, got.hit, got.sat);
        end
        hit_count += want.hit;
        sat_count += want.sat;
        if (want.streak > longest_streak) longest_streak = want.streak;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("seeded_prng_zero_streak_search_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic wait_for_drain();
    @(negedge clk);
    while (seed_q.size() != 0 || in_valid || streak_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [BOUND_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_DRAW_BOUND: model_bound = val;
      REG_STREAK_THRESHOLD: model_thresh = val[THRESH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [BOUND_W-1:0] bnd, input logic [THRESH_W-1:0] thr);
    wait_for_drain();
    write_reg(REG_DRAW_BOUND, bnd);
    write_reg(REG_STREAK_THRESHOLD, {{(BOUND_W - THRESH_W){1'b0}}, thr});
    settings_count++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned n_items, random_items, phase_idx, i;
    logic [BOUND_W-1:0]  bnd;
    logic [THRESH_W-1:0] thr;
    logic [63:0]         s;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings; simple edge seeds and seeds that zero either half of the seeding input.
    seed_q.push_back(64'h0);
    seed_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    seed_q.push_back(64'h1);
    seed_q.push_back(64'h8000_0000_0000_0000);
    seed_q.push_back(SILVER);
    seed_q.push_back((64'h0 - GOLDEN) ^ SILVER);
    // A zero bound saturates every seed; the hit is judged on the saturated count.
    apply_setting(31'd0, 11'd1024);
    seed_q.push_back(64'h0);
    seed_q.push_back(64'h0123_4567_89AB_CDEF);
    apply_setting(31'd1, 11'd0);
    seed_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    seed_q.push_back(64'hDEAD_BEEF_0000_0001);
    apply_setting(31'h7FFF_FFFF, 11'd0);
    for (i = 0; i < 4; i++) seed_q.push_back({$urandom, $urandom});
    // This bound makes the rejection limit nearly equal to the bound itself.
    apply_setting(31'h5555_5556, 11'd1);
    for (i = 0; i < 4; i++) seed_q.push_back({$urandom, $urandom});
    apply_setting(31'd2, 11'd1);
    for (i = 0; i < 5; i++) seed_q.push_back({$urandom, $urandom});

    random_items = 0;
    phase_idx = 0;
    while (random_items < 830) begin
      if (phase_idx == 0) begin
        bnd = 31'd3;
        thr = 11'd2;
      end else begin
        case ($urandom_range(0, 9))
          0: bnd = 31'd2;
          1: bnd = 31'd3;
          2: bnd = 31'd4;
          3: bnd = 31'($urandom_range(2, 16));
          4: bnd = 31'($urandom_range(17, 1000));
          5: bnd = 31'h5555_5556;
          6: bnd = 31'($urandom);
          7: bnd = 31'h7FFF_FFFF;
          8: bnd = 31'($urandom_range(5, 9));
          default: bnd = 31'($urandom_range(0, 1));
        endcase
        case ($urandom_range(0, 6))
          0: thr = 11'd0;
          1: thr = 11'd1;
          2: thr = 11'd2;
          3: thr = 11'($urandom_range(3, 8));
          4: thr = 11'($urandom_range(0, 2047));
          5: thr = 11'd1024;
          default: thr = 11'd2047;
        endcase
      end
      apply_setting(bnd, thr);
      n_items = (bnd <= 1) ? 3 : $urandom_range(40, 90);
      for (i = 0; i < n_items; i++) begin
        case ($urandom_range(0, 7))
          0: s = 64'($urandom_range(0, 255));
          1: s = ~64'($urandom_range(0, 255));
          2: s = {$urandom, 32'h0};
          default: s = {$urandom, $urandom};
        endcase
        seed_q.push_back(s);
      end
      random_items += n_items;
      if (phase_idx == 0) begin
        // The receiver holds off long enough to back the block up into its input,
        // and partway through the sender stops until every word has come back.
        long_hold_req = 1'b1;
        while (seed_q.size() > n_items / 2) @(negedge clk);
        send_hold = 1'b1;
        while (in_valid || streak_expect_q.size() != 0) @(negedge clk);
        send_hold = 1'b0;
      end
      phase_idx++;
    end

    wait_for_drain();
    repeat (40) @(posedge clk);
    if (streak_expect_q.size() != 0) mismatches += streak_expect_q.size();
    $display("checked %0d words under %0d register settings, including zero and full bounds",
             words_checked, settings_count);
    $display("%0d hits, %0d saturated streaks, %0d rejected draws, longest streak %0d",
             hit_count, sat_count, rejected_draws, longest_streak);
    if (mismatches == 0) begin
      $display("seeded_prng_zero_streak_search_tb OK");
    end else begin
      $display("seeded_prng_zero_streak_search_tb NOT OK");
    end
    $finish;
  end

endmodule
